/* rtl/core/spq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions of the stable priority task queue
// Sizes, operation and status codes, and the types that travel between the
// queue cells, the cell row and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int ID_W           = 64;
    localparam int ACTION_W       = 2;
    localparam int STATUS_W       = 2;
    localparam int PRIO_PORT_W    = 8;
    localparam int COUNT_PORT_W   = 5;
    localparam int COUNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SERVE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic                      valid;
        logic [PRIORITY_WIDTH-1:0] pri;
        logic [ID_W-1:0]           id;
    } entry_t;

    // Operation broadcast to every cell in the cycle an item is accepted.
    typedef struct packed {
        logic                      ins_en;
        logic                      rem_en;
        logic                      srv_en;
        logic [PRIORITY_WIDTH-1:0] new_pri;
        logic [ID_W-1:0]           new_id;
    } cell_ctrl_t;

    // Summary of the row seen by the top level.
    typedef struct packed {
        logic   full;
        logic   empty;
        logic   found;
        entry_t head_next;
    } row_status_t;

endpackage
`default_nettype wire

/* rtl/core/spq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted task row
// Holds one entry and picks its next value from itself, its upper neighbor,
// its lower neighbor or the new task, using local compares only.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     prev_entry,
    input  wire entry_t     next_entry,
    input  wire logic       ins_prev,
    input  wire logic       match_prev,
    output logic            ins_here,
    output logic            match_upto,
    output entry_t          cur_entry,
    output entry_t          nxt_entry
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [PRIORITY_WIDTH-1:0] pri_reg;
    logic [PRIORITY_WIDTH-1:0] pri_next;
    logic [ID_W-1:0]           id_reg;
    logic [ID_W-1:0]           id_next;

    // The row is sorted and packed, so this flag rises once along the row.
    assign ins_here   = !valid_reg || (pri_reg < ctrl.new_pri);
    assign match_upto = match_prev || (valid_reg && (id_reg == ctrl.new_id));

    always_comb
    begin
        valid_next = valid_reg;
        pri_next   = pri_reg;
        id_next    = id_reg;
        if (ctrl.ins_en)
        begin
            if (ins_prev)
            begin
                valid_next = prev_entry.valid;
                pri_next   = prev_entry.pri;
                id_next    = prev_entry.id;
            end
            else if (ins_here)
            begin
                valid_next = 1'b1;
                pri_next   = ctrl.new_pri;
                id_next    = ctrl.new_id;
            end
        end
        else if (ctrl.srv_en || (ctrl.rem_en && match_upto))
        begin
            valid_next = next_entry.valid;
            pri_next   = next_entry.pri;
            id_next    = next_entry.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg <= pri_next;
        id_reg  <= id_next;
    end

    assign cur_entry = '{valid: valid_reg, pri: pri_reg, id: id_reg};
    assign nxt_entry = '{valid: valid_next, pri: pri_next, id: id_next};

endmodule
`default_nettype wire

/* rtl/core/spq_row.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_row: the row of queue cells
// Links each cell to its neighbors and reports fullness, emptiness, the
// remove match and the head after the current operation.
// ----------------------------------------------------------------------------
module spq_row import spq_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    output row_status_t     row_status
);

    entry_t            cur   [QUEUE_DEPTH];
    entry_t            nxt   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] ins_flag;
    logic [QUEUE_DEPTH-1:0] match_flag;

    localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, pri: '0, id: '0};

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   ins_p;
        logic   match_p;

        if (i == 0)
        begin : g_first
            assign prev_e  = EMPTY_ENTRY;
            assign ins_p   = 1'b0;
            assign match_p = 1'b0;
        end
        else
        begin : g_inner
            assign prev_e  = cur[i-1];
            assign ins_p   = ins_flag[i-1];
            assign match_p = match_flag[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_e = EMPTY_ENTRY;
        end
        else
        begin : g_body
            assign next_e = cur[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .ins_prev   (ins_p),
            .match_prev (match_p),
            .ins_here   (ins_flag[i]),
            .match_upto (match_flag[i]),
            .cur_entry  (cur[i]),
            .nxt_entry  (nxt[i])
        );
    end

    assign row_status.full      = cur[QUEUE_DEPTH-1].valid;
    assign row_status.empty     = !cur[0].valid;
    assign row_status.found     = match_flag[QUEUE_DEPTH-1];
    assign row_status.head_next = nxt[0];

endmodule
`default_nettype wire

/* rtl/core/stable_priority_task_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_task_queue: sorted task queue with stable ordering
// Row of cells holding tasks in descending priority, first in first out
// among equal priorities, with insert, remove by id and serve.
// ----------------------------------------------------------------------------
// The queue takes one item per clock cycle and shows its result in the
// output register in the cycle after the item is accepted; the input
// stalls only while a finished result waits on a stalled output. Each
// operation is applied to every cell of the row in the same cycle; the
// remove search passes its match flag from cell to cell along the row,
// which sets the longest path.
module stable_priority_task_queue import spq_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [ACTION_W-1:0]      action,
    input  wire logic [PRIO_PORT_W-1:0]   priority_req,
    input  wire logic [ID_W-1:0]          task_id,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [STATUS_W-1:0]           status,
    output logic                          head_valid,
    output logic [PRIO_PORT_W-1:0]        head_priority,
    output logic [ID_W-1:0]               head_id,
    output logic [COUNT_PORT_W-1:0]       task_count
);

    logic                 accept;
    cell_ctrl_t           ctrl;
    row_status_t          row_status;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    entry_t               head_reg;
    logic [COUNT_W-1:0]   count_out_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        ctrl.new_pri = PRIORITY_WIDTH'(priority_req);
        ctrl.new_id  = task_id;
        ctrl.ins_en  = accept && (action == ACT_INSERT) && !row_status.full;
        ctrl.rem_en  = accept && (action == ACT_REMOVE);
        ctrl.srv_en  = accept && (action == ACT_SERVE) && !row_status.empty;
    end

    spq_row u_row (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .row_status (row_status)
    );

    always_comb
    begin
        status_next = ST_DONE;
        count_next  = count_reg;
        case (action)
            ACT_INSERT:
            begin
                if (row_status.full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + COUNT_W'(1);
            end
            ACT_REMOVE:
            begin
                if (row_status.found)
                    count_next = count_reg - COUNT_W'(1);
                else
                    status_next = ST_NOT_FOUND;
            end
            ACT_SERVE:
            begin
                if (row_status.empty)
                    status_next = ST_EMPTY;
                else
                    count_next = count_reg - COUNT_W'(1);
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            head_reg      <= row_status.head_next;
            count_out_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign head_valid    = head_reg.valid;
    // An empty queue shows zero in the head fields.
    assign head_priority = head_reg.valid ? PRIO_PORT_W'(head_reg.pri) : '0;
    assign head_id       = head_reg.valid ? head_reg.id : '0;
    assign task_count    = COUNT_PORT_W'(count_out_reg);

endmodule
`default_nettype wire

/* rtl/core/spq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the stable priority task queue
// Watches results against the queue's own bookkeeping and is bound to the
// top level.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_stall,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic [STATUS_W-1:0]      status,
    input wire logic                     head_valid,
    input wire logic [COUNT_PORT_W-1:0]  task_count
);

    // Every accepted item leaves a result in the output register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted item produced no result");

    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (task_count != '0)))
        else $error("head valid disagrees with task count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> (task_count == '0))
        else $error("empty status with tasks held");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |->
        (task_count == COUNT_PORT_W'(QUEUE_DEPTH)))
        else $error("full status with free slots");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
        && $stable(task_count)))
        else $error("stalled result changed");

endmodule

bind stable_priority_task_queue spq_checker u_spq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .head_valid (head_valid),
    .task_count (task_count)
);
`default_nettype wire
